>>> design/lqr_pkg.sv
`timescale 1ns / 1ps
// lqr_pkg: shared constants, config register types and the cosine table
// for the lqr balance torque block. no dependencies.

package lqr_pkg;

  localparam int COS_DEPTH    = 256;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int TAYLOR_TERMS = 10;

  localparam int PITCH_W = 19;
  localparam int MAG_W   = PITCH_W;
  localparam int COS_W   = 17;
  localparam int SCOS_W  = COS_W + 1;
  localparam int IDX_W   = $clog2(COS_DEPTH + 1);
  localparam int N_W     = $clog2(3 * COS_DEPTH);

  // table position n = floor((a*D*2^15 + H) / (2H)), estimated by reciprocal
  localparam longint POS_RECIP = (longint'(COS_DEPTH) <<< 46) / HALF_PI_Q30;
  localparam int RECIP_W = $clog2(POS_RECIP + 1);
  localparam int AM_W    = MAG_W + RECIP_W;
  localparam int AD_W    = MAG_W + IDX_W;
  localparam int M_W     = AD_W + 16;
  localparam longint POS_DIV = 2 * HALF_PI_Q30;
  localparam int NEK_W   = N_W + 32;

  // register stages from the pitch register to the signed cosine register
  localparam int COS_LAT = 7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_VELOCITY   = 3'd0,
    REG_GAIN_PITCH      = 3'd1,
    REG_GAIN_PITCH_RATE = 3'd2,
    REG_WHEEL_RADIUS    = 3'd3,
    REG_COM_HEIGHT      = 3'd4,
    REG_MAX_TORQUE      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] gain_velocity;
    logic signed [31:0] gain_pitch;
    logic signed [31:0] gain_pitch_rate;
    logic [30:0]        wheel_radius;
    logic [30:0]        com_height;
    logic [30:0]        max_torque;
  } cfg_t;

  // ceil(2^64 / ((2k-1)*2k)), exact floor division for series terms below 2^34
  localparam logic [127:0] TERM_ONE      = 128'd1 << 64;
  localparam logic [127:0] TERM_RECIP_1  = (TERM_ONE + 128'd1) / 128'd2;
  localparam logic [127:0] TERM_RECIP_2  = (TERM_ONE + 128'd11) / 128'd12;
  localparam logic [127:0] TERM_RECIP_3  = (TERM_ONE + 128'd29) / 128'd30;
  localparam logic [127:0] TERM_RECIP_4  = (TERM_ONE + 128'd55) / 128'd56;
  localparam logic [127:0] TERM_RECIP_5  = (TERM_ONE + 128'd89) / 128'd90;
  localparam logic [127:0] TERM_RECIP_6  = (TERM_ONE + 128'd131) / 128'd132;
  localparam logic [127:0] TERM_RECIP_7  = (TERM_ONE + 128'd181) / 128'd182;
  localparam logic [127:0] TERM_RECIP_8  = (TERM_ONE + 128'd239) / 128'd240;
  localparam logic [127:0] TERM_RECIP_9  = (TERM_ONE + 128'd305) / 128'd306;
  localparam logic [127:0] TERM_RECIP_10 = (TERM_ONE + 128'd379) / 128'd380;

  function automatic logic [127:0] term_recip(int k);
    case (k)
      1: return TERM_RECIP_1;
      2: return TERM_RECIP_2;
      3: return TERM_RECIP_3;
      4: return TERM_RECIP_4;
      5: return TERM_RECIP_5;
      6: return TERM_RECIP_6;
      7: return TERM_RECIP_7;
      8: return TERM_RECIP_8;
      9: return TERM_RECIP_9;
      default: return TERM_RECIP_10;
    endcase
  endfunction

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_DEPTH];

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint t_rnd;
    logic [127:0] prod;
    for (int i = 0; i <= COS_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * i + COS_DEPTH / 2) / COS_DEPTH;
      x2   = (x * x + (64'sd1 <<< 29)) >>> 30;
      term = 64'sd1 <<< 30;
      sum  = term;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        t_rnd = (term * x2 + (64'sd1 <<< 29)) >>> 30;
        prod  = 128'(t_rnd) * term_recip(k);
        term  = longint'(prod[127:64]);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      rom[i] = COS_W'((sum + (64'sd1 <<< 13)) >>> 14);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

>>> design/lqr_cfg_regs.sv
`timescale 1ns / 1ps
// lqr_cfg_regs: configuration register file with a valid/ready write port.
// depends on lqr_pkg for the register index codes and cfg_t.

module lqr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lqr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lqr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lqr_pkg::cfg_t                    cfg
);

  lqr_pkg::cfg_t cfg_r;
  lqr_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lqr_pkg::REG_GAIN_VELOCITY:   cfg_nxt.gain_velocity   = $signed(cfg_data);
        lqr_pkg::REG_GAIN_PITCH:      cfg_nxt.gain_pitch      = $signed(cfg_data);
        lqr_pkg::REG_GAIN_PITCH_RATE: cfg_nxt.gain_pitch_rate = $signed(cfg_data);
        lqr_pkg::REG_WHEEL_RADIUS:    cfg_nxt.wheel_radius    = cfg_data[30:0];
        lqr_pkg::REG_COM_HEIGHT:      cfg_nxt.com_height      = cfg_data[30:0];
        lqr_pkg::REG_MAX_TORQUE:      cfg_nxt.max_torque      = cfg_data[30:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/lqr_cos_lookup.sv
`timescale 1ns / 1ps
// lqr_cos_lookup: pipelined quarter-wave cosine of the pitch angle.
// depends on lqr_pkg for table and widths.

module lqr_cos_lookup (
  input  logic                               clk,
  input  logic signed [lqr_pkg::PITCH_W-1:0] pitch,
  output logic signed [lqr_pkg::SCOS_W-1:0]  cos_val
);

  logic [lqr_pkg::MAG_W-1:0]  mag;
  logic [lqr_pkg::PITCH_W-1:0] pitch_u;

  logic [lqr_pkg::AM_W-1:0]   am_r, am_nxt;
  logic [lqr_pkg::AD_W-1:0]   ad_r, ad_nxt;
  logic [63:0]                am_rnd;
  logic [lqr_pkg::N_W-1:0]    ne_r, ne_nxt;
  logic [lqr_pkg::M_W-1:0]    m_r, m_nxt;
  logic [lqr_pkg::NEK_W-1:0]  nek_r, nek_nxt;
  logic [lqr_pkg::N_W-1:0]    ne2_r;
  logic [lqr_pkg::M_W-1:0]    m2_r;
  logic [63:0]                rem;
  logic [lqr_pkg::N_W-1:0]    n_r, n_nxt;
  logic [1:0]                 quad;
  logic [lqr_pkg::IDX_W-1:0]  rr;
  logic [lqr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       neg_r, neg_nxt;
  logic [lqr_pkg::COS_W-1:0]  tv_r;
  logic                       neg2_r;
  logic signed [lqr_pkg::SCOS_W-1:0] tv_s;
  logic signed [lqr_pkg::SCOS_W-1:0] cos_r, cos_nxt;

  assign cos_val = cos_r;

  always_comb begin
    pitch_u = pitch;
    mag     = pitch_u[lqr_pkg::PITCH_W-1] ? (~pitch_u + 1'b1) : pitch_u;
    am_nxt  = lqr_pkg::AM_W'(mag) * lqr_pkg::AM_W'(lqr_pkg::POS_RECIP);
    ad_nxt  = lqr_pkg::AD_W'(mag) * lqr_pkg::AD_W'(lqr_pkg::COS_DEPTH);

    // position estimate, at most one step low
    am_rnd  = 64'(am_r) + 64'h0000_0000_8000_0000;
    ne_nxt  = am_rnd[32 +: lqr_pkg::N_W];
    m_nxt   = (lqr_pkg::M_W'(ad_r) << 15) + lqr_pkg::M_W'(lqr_pkg::HALF_PI_Q30);

    nek_nxt = lqr_pkg::NEK_W'(ne_r) * lqr_pkg::NEK_W'(lqr_pkg::POS_DIV);

    rem     = 64'(m2_r) - 64'(nek_r);
    n_nxt   = ne2_r + lqr_pkg::N_W'(rem >= 64'(lqr_pkg::POS_DIV));

    // quadrant split, position stays below three quarter turns
    if (n_r >= lqr_pkg::N_W'(2 * lqr_pkg::COS_DEPTH)) begin
      quad = 2'd2;
      rr   = lqr_pkg::IDX_W'(n_r - lqr_pkg::N_W'(2 * lqr_pkg::COS_DEPTH));
    end else if (n_r >= lqr_pkg::N_W'(lqr_pkg::COS_DEPTH)) begin
      quad = 2'd1;
      rr   = lqr_pkg::IDX_W'(n_r - lqr_pkg::N_W'(lqr_pkg::COS_DEPTH));
    end else begin
      quad = 2'd0;
      rr   = lqr_pkg::IDX_W'(n_r);
    end
    idx_nxt = quad[0] ? (lqr_pkg::IDX_W'(lqr_pkg::COS_DEPTH) - rr) : rr;
    neg_nxt = quad[0] ^ quad[1];

    tv_s    = $signed({1'b0, tv_r});
    cos_nxt = neg2_r ? -tv_s : tv_s;
  end

  always_ff @(posedge clk) begin
    am_r   <= am_nxt;
    ad_r   <= ad_nxt;
    ne_r   <= ne_nxt;
    m_r    <= m_nxt;
    nek_r  <= nek_nxt;
    ne2_r  <= ne_r;
    m2_r   <= m_r;
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    tv_r   <= lqr_pkg::COS_ROM[idx_r];
    neg2_r <= neg_r;
    cos_r  <= cos_nxt;
  end

endmodule

>>> design/lqr_balance_torque.sv
`timescale 1ns / 1ps
// lqr_balance_torque: lqr balance controller, body velocity estimate and
// clamped wheel torque. depends on lqr_pkg, lqr_cfg_regs, lqr_cos_lookup.
// start is registered into vld_r[0] and shifted along vld_r to out_valid_r.
// throughput: one item per cycle; busy stays low.
// the receiver cannot stall; each result is shown for one cycle only.
// synchronous reset clears the valid pipeline and all config registers to 0.

module lqr_balance_torque (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 in_right_wheel_velocity,
  input  logic signed [31:0]                 in_left_wheel_velocity,
  input  logic signed [lqr_pkg::PITCH_W-1:0] in_pitch_angle,
  input  logic signed [31:0]                 in_pitch_rate,
  output logic                               out_valid,
  output logic signed [31:0]                 out_wheel_torque,
  output logic signed [31:0]                 out_body_velocity,
  output logic                               out_torque_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lqr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lqr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ST_COS = lqr_pkg::COS_LAT;
  localparam int ST_HC  = ST_COS + 2;
  localparam int ST_VEL = ST_COS + 4;
  localparam int ST_TQ  = ST_COS + 6;

  lqr_pkg::cfg_t cfg;

  logic                               vld_r [0:ST_TQ];
  logic signed [31:0]                 rwv_r, lwv_r, rate_r;
  logic signed [lqr_pkg::PITCH_W-1:0] pitch_r;

  logic signed [32:0] sum1_r, sum1_nxt;
  logic signed [50:0] gpp1_r, gpp1_nxt;
  logic signed [63:0] grp1_r, grp1_nxt;
  logic signed [63:0] wrp2_r, wrp2_nxt;
  logic signed [47:0] tp_nxt, rv_nxt;
  logic signed [31:0] rate_d_r [1:ST_HC];
  logic signed [47:0] tp_d_r [2:ST_TQ-1];
  logic signed [47:0] rv_d_r [3:ST_VEL-1];
  logic signed [lqr_pkg::SCOS_W-1:0] cos_val;
  logic signed [48:0] hcp_r, hcp_nxt;
  logic signed [31:0] hc_r, hc_nxt;
  logic signed [63:0] hr_r, hr_nxt;
  logic signed [63:0] vsum;
  logic signed [31:0] vel_nxt;
  logic signed [31:0] vel_d_r [ST_VEL:ST_TQ];
  logic signed [63:0] gvp_r, gvp_nxt;
  logic signed [63:0] tq_full;
  logic signed [47:0] tq_r, tq_nxt;
  logic signed [47:0] lim, nlim;
  logic signed [31:0] wr_s, ch_s;

  logic               out_valid_r;
  logic signed [31:0] torque_r, torque_nxt;
  logic signed [31:0] bvel_r;
  logic               sat_r, sat_nxt;

  assign busy                 = 1'b0;
  assign out_valid            = out_valid_r;
  assign out_wheel_torque     = torque_r;
  assign out_body_velocity    = bvel_r;
  assign out_torque_saturated = sat_r;

  lqr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lqr_cos_lookup u_cos (
    .clk     (clk),
    .pitch   (pitch_r),
    .cos_val (cos_val)
  );

  always_comb begin
    wr_s     = $signed({1'b0, cfg.wheel_radius});
    ch_s     = $signed({1'b0, cfg.com_height});

    sum1_nxt = 33'(rwv_r) + 33'(lwv_r);
    gpp1_nxt = $signed(cfg.gain_pitch) * pitch_r;
    grp1_nxt = $signed(cfg.gain_pitch_rate) * rate_r;

    wrp2_nxt = wr_s * sum1_r;
    tp_nxt   = 48'(((64'(gpp1_r) + 64'sd65536) >>> 17) + ((grp1_r + 64'sd65536) >>> 17));

    rv_nxt   = 48'((wrp2_r + 64'sd65536) >>> 17);

    hcp_nxt  = ch_s * cos_val;
    hc_nxt   = 32'((hcp_r + 49'sd32768) >>> 16);
    hr_nxt   = hc_r * rate_d_r[ST_HC];

    vsum = 64'(rv_d_r[ST_VEL-1]) + ((hr_r + 64'sd32768) >>> 16);
    if (vsum > 64'sd2147483647) begin
      vel_nxt = 32'sh7fff_ffff;
    end else if (vsum < -64'sd2147483648) begin
      vel_nxt = 32'sh8000_0000;
    end else begin
      vel_nxt = vsum[31:0];
    end

    gvp_nxt = $signed(cfg.gain_velocity) * vel_d_r[ST_VEL];
    tq_full = -(((gvp_r + 64'sd65536) >>> 17) + 64'(tp_d_r[ST_TQ-1]));
    tq_nxt  = tq_full[47:0];

    lim  = $signed(48'(cfg.max_torque));
    nlim = -lim;
    if (tq_r > lim) begin
      torque_nxt = lim[31:0];
      sat_nxt    = 1'b1;
    end else if (tq_r < nlim) begin
      torque_nxt = nlim[31:0];
      sat_nxt    = 1'b1;
    end else begin
      torque_nxt = tq_r[31:0];
      sat_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_TQ; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start & ~busy;
      for (int k = 1; k <= ST_TQ; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[ST_TQ];
    end
  end

  always_ff @(posedge clk) begin
    rwv_r   <= in_right_wheel_velocity;
    lwv_r   <= in_left_wheel_velocity;
    pitch_r <= in_pitch_angle;
    rate_r  <= in_pitch_rate;

    sum1_r  <= sum1_nxt;
    gpp1_r  <= gpp1_nxt;
    grp1_r  <= grp1_nxt;
    wrp2_r  <= wrp2_nxt;

    rate_d_r[1] <= rate_r;
    for (int k = 2; k <= ST_HC; k++) begin
      rate_d_r[k] <= rate_d_r[k-1];
    end
    tp_d_r[2] <= tp_nxt;
    for (int k = 3; k <= ST_TQ - 1; k++) begin
      tp_d_r[k] <= tp_d_r[k-1];
    end
    rv_d_r[3] <= rv_nxt;
    for (int k = 4; k <= ST_VEL - 1; k++) begin
      rv_d_r[k] <= rv_d_r[k-1];
    end

    hcp_r <= hcp_nxt;
    hc_r  <= hc_nxt;
    hr_r  <= hr_nxt;

    vel_d_r[ST_VEL] <= vel_nxt;
    for (int k = ST_VEL + 1; k <= ST_TQ; k++) begin
      vel_d_r[k] <= vel_d_r[k-1];
    end

    gvp_r <= gvp_nxt;
    tq_r  <= tq_nxt;

    torque_r <= torque_nxt;
    sat_r    <= sat_nxt;
    bvel_r   <= vel_d_r[ST_TQ];
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for lqr_balance_torque, with a scoreboard class that
// predicts body velocity and clamped wheel torque for each item and checks every result.
// depends on lqr_pkg and lqr_balance_torque.

module tb;

  localparam int CLK_HALF = 6;
  localparam int COS_STEPS = lqr_pkg::COS_DEPTH;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam logic [lqr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lqr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [31:0] torque;
    logic signed [31:0] velocity;
    logic               clamped;
  } torque_result_t;

  class torque_scoreboard;
    logic signed [31:0] k_vel, k_pitch, k_rate;
    logic [30:0]        radius, height, limit;
    longint             cos_tab[COS_STEPS + 1];
    torque_result_t     due_q[$];
    int                 checked, n_clamped, errors, shown;

    function new();
      longint x, x2, term, sum;
      for (int i = 0; i <= COS_STEPS; i++) begin
        x    = (QUARTER_TURN_Q30 * i + COS_STEPS / 2) / COS_STEPS;
        x2   = half_up(x * x, 30);
        term = 64'sd1 <<< 30;
        sum  = term;
        for (int k = 1; k <= 10; k++) begin
          term = half_up(term * x2, 30) / ((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            sum -= term;
          end else begin
            sum += term;
          end
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        cos_tab[i] = half_up(sum, 14);
      end
      k_vel = '0; k_pitch = '0; k_rate = '0;
      radius = '0; height = '0; limit = '0;
    endfunction

    function longint half_up(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint cosine_at(longint pitch);
      longint a, pos, step;
      int quad, rem;
      a    = (pitch < 0) ? -pitch : pitch;
      pos  = ((a * COS_STEPS) <<< 30) / QUARTER_TURN_Q30;
      step = (pos + (64'sd1 <<< 15)) >>> 16;
      quad = int'((step / COS_STEPS) % 4);
      rem  = int'(step % COS_STEPS);
      case (quad)
        0: return cos_tab[rem];
        1: return -cos_tab[COS_STEPS - rem];
        2: return -cos_tab[rem];
        default: return cos_tab[COS_STEPS - rem];
      endcase
    endfunction

    function void set_reg(logic [lqr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        lqr_pkg::REG_GAIN_VELOCITY:   k_vel   = data;
        lqr_pkg::REG_GAIN_PITCH:      k_pitch = data;
        lqr_pkg::REG_GAIN_PITCH_RATE: k_rate  = data;
        lqr_pkg::REG_WHEEL_RADIUS:    radius  = data[30:0];
        lqr_pkg::REG_COM_HEIGHT:      height  = data[30:0];
        lqr_pkg::REG_MAX_TORQUE:      limit   = data[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic signed [31:0] right, logic signed [31:0] left,
                            logic signed [lqr_pkg::PITCH_W-1:0] pitch,
                            logic signed [31:0] rate);
      longint hc, vel, torque, lim;
      torque_result_t want;
      hc  = half_up(longint'(height) * cosine_at(longint'(pitch)), 16);
      vel = half_up(longint'(radius) * (longint'(right) + longint'(left)), 17)
          + half_up(hc * longint'(rate), 16);
      if (vel > 64'sd2147483647) vel = 64'sd2147483647;
      if (vel < -64'sd2147483648) vel = -64'sd2147483648;
      torque = -(half_up(longint'(k_vel) * vel, 17)
               + half_up(longint'(k_pitch) * longint'(pitch), 17)
               + half_up(longint'(k_rate) * longint'(rate), 17));
      lim = longint'(limit);
      want.clamped = 1'b0;
      if (torque > lim) begin
        torque = lim;
        want.clamped = 1'b1;
      end
      if (torque < -lim) begin
        torque = -lim;
        want.clamped = 1'b1;
      end
      want.torque   = torque[31:0];
      want.velocity = vel[31:0];
      due_q.push_back(want);
    endfunction

    function void check_result(logic signed [31:0] torque, logic signed [31:0] velocity,
                               logic clamped_flag);
      torque_result_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: torque %0d velocity %0d sat %0b",
                   torque, velocity, clamped_flag);
        end
        return;
      end
      want = due_q.pop_front();
      if (want.clamped) n_clamped++;
      if (torque !== want.torque || velocity !== want.velocity
          || clamped_flag !== want.clamped) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected torque %0d velocity %0d sat %0b, got %0d %0d %0b",
                   want.torque, want.velocity, want.clamped, torque, velocity, clamped_flag);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void close_out();
      if (due_q.size() != 0) begin
        errors += due_q.size();
        $display("%0d results never arrived", due_q.size());
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [31:0]                 in_right_wheel_velocity = '0;
  logic signed [31:0]                 in_left_wheel_velocity = '0;
  logic signed [lqr_pkg::PITCH_W-1:0] in_pitch_angle = '0;
  logic signed [31:0]                 in_pitch_rate = '0;
  logic                               out_valid;
  logic signed [31:0]                 out_wheel_torque;
  logic signed [31:0]                 out_body_velocity;
  logic                               out_torque_saturated;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [lqr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [lqr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  torque_scoreboard sb;
  int items_sent = 0;
  int cfg_sets = 0;
  int gap_pct = 25;

  lqr_balance_torque i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_right_wheel_velocity (in_right_wheel_velocity),
    .in_left_wheel_velocity  (in_left_wheel_velocity),
    .in_pitch_angle          (in_pitch_angle),
    .in_pitch_rate           (in_pitch_rate),
    .out_valid               (out_valid),
    .out_wheel_torque        (out_wheel_torque),
    .out_body_velocity       (out_body_velocity),
    .out_torque_saturated    (out_torque_saturated),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        sb.note_item(in_right_wheel_velocity, in_left_wheel_velocity, in_pitch_angle,
                     in_pitch_rate);
      end
      if (out_valid) sb.check_result(out_wheel_torque, out_body_velocity, out_torque_saturated);
    end
  end

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return w;
      2: return {{13{w[18]}}, w[18:0]};
      3, 4: return {{8{w[23]}}, w[23:0]};
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [lqr_pkg::PITCH_W-1:0] pick_pitch();
    int v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return v[lqr_pkg::PITCH_W-1:0];
      1: begin
        v = v[0] ? 205887 : -205887;
        return v[lqr_pkg::PITCH_W-1:0];
      end
      default: begin
        v = int'($urandom_range(0, 411774)) - 205887;
        return v[lqr_pkg::PITCH_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 3) == 0) return w;
    return {{10{w[21]}}, w[21:0]};
  endfunction

  task automatic send_item(logic [31:0] right, logic [31:0] left,
                           logic [lqr_pkg::PITCH_W-1:0] pitch, logic [31:0] rate);
    start                   <= 1'b1;
    in_right_wheel_velocity <= right;
    in_left_wheel_velocity  <= left;
    in_pitch_angle          <= pitch;
    in_pitch_rate           <= rate;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    send_item(pick_word(), pick_word(), pick_pitch(), pick_word());
  endtask

  task automatic send_corner(int k);
    case (k)
      0: send_item(32'h0, 32'h0, 19'd0, 32'h0);
      1: send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 19'd0, 32'h0);
      2: send_item(32'h8000_0000, 32'h8000_0000, 19'd0, 32'h0);
      3: send_item(32'h7FFF_FFFF, 32'h8000_0000, 19'd205887, 32'd65536);
      4: send_item(32'd65536, 32'd65536, -19'sd205887, -32'sd65536);
      5: send_item(32'h0, 32'h0, 19'h3FFFF, 32'h7FFF_FFFF);
      6: send_item(32'h0, 32'h0, 19'h40000, 32'h8000_0000);
      7: send_item(32'h0, 32'h0, 19'd102944, 32'd262144);
      8: send_item(32'd655360, -32'sd196608, -19'sd154416, -32'sd131072);
      9: send_item(32'h0, 32'h0, 19'd32768, 32'h0);
      10: send_item(32'h0, 32'h0, -19'sd32768, 32'h0);
      11: send_item(32'd131072, 32'd131072, 19'd655, 32'd6554);
      default: send_random();
    endcase
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [lqr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] gv, logic [31:0] gp, logic [31:0] gr,
                             logic [31:0] wr, logic [31:0] ch, logic [31:0] mt,
                             bit with_spare);
    if (with_spare) begin
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
    end
    write_reg(lqr_pkg::REG_GAIN_VELOCITY, gv);
    write_reg(lqr_pkg::REG_GAIN_PITCH, gp);
    write_reg(lqr_pkg::REG_GAIN_PITCH_RATE, gr);
    write_reg(lqr_pkg::REG_WHEEL_RADIUS, wr);
    write_reg(lqr_pkg::REG_COM_HEIGHT, ch);
    write_reg(lqr_pkg::REG_MAX_TORQUE, mt);
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  task automatic random_config(bit with_spare);
    logic [31:0] wr, ch, mt;
    wr = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 131072);
    ch = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 131072);
    case ($urandom_range(0, 5))
      0: mt = 32'h0;
      1: mt = $urandom;
      default: mt = $urandom_range(0, 4194304);
    endcase
    load_config(pick_gain(), pick_gain(), pick_gain(), wr, ch, mt, with_spare);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values
    send_corner(0);
    send_corner(5);
    wait_results();

    load_config(-32'sd98304, -32'sd2621440, -32'sd196608, 32'd3277, 32'd19661,
                32'd131072, 1'b0);
    for (int k = 0; k <= 12; k++) send_corner(k);
    wait_results();

    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_corner(1);
    send_corner(2);
    send_corner(5);
    send_corner(6);
    send_corner(12);
    wait_results();

    // zero torque limit
    load_config(-32'sd98304, -32'sd2621440, -32'sd196608, 32'd3277, 32'd19661,
                32'd0, 1'b0);
    send_corner(0);
    send_corner(9);
    send_corner(11);

    for (int phase = 0; phase < 6; phase++) begin
      wait_results();
      random_config(phase % 2 == 0);
      gap_pct = 25;
      for (int n = 0; n < 155; n++) begin
        if (phase == 5) begin
          gap_pct = 0;
        end else if (n % 40 == 0) begin
          gap_pct = 25 * $urandom_range(0, 2);
        end
        send_random();
      end
    end

    wait_results();
    repeat (20) @(posedge clk);
    sb.close_out();
    $display("sent %0d items over %0d register settings, %0d results checked",
             items_sent, cfg_sets, sb.checked);
    $display("%0d torques clamped, %0d errors", sb.n_clamped, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(CLK_HALF * 2 * 200000);
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
design/lqr_pkg.sv
design/lqr_cfg_regs.sv
design/lqr_cos_lookup.sv
design/lqr_balance_torque.sv
sim/tb.sv
